/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on the rising edge, off while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// checked on the rising edge, also during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed");

`endif

/* src/sc2a_pkg.sv */
// ----------------------------------------------------------------------------
// sc2a_pkg
// constants, key codes and the set-1 us layout lookup for the scan code fifo
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sc2a_pkg;

	localparam int DEPTH = 256;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CHAR_W = 7;
	localparam int CODE_W = 8;

	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [CODE_W-2:0] KEY_LSHIFT = 7'h2A;
	localparam logic [CODE_W-2:0] KEY_RSHIFT = 7'h36;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CHAR_W-1:0] char_t;

	function automatic ptr_t ptr_next(input ptr_t p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// set-1 make code to ascii, zero for unmapped keys
	function automatic char_t scan_to_ascii(input logic [CODE_W-2:0] code, input logic shift);
		char_t plain;
		char_t shifted;
		plain = '0;
		shifted = '0;
		case (code)
			7'd1: begin plain = 7'h1B; shifted = 7'h1B; end
			7'd2: begin plain = 7'h31; shifted = 7'h21; end
			7'd3: begin plain = 7'h32; shifted = 7'h40; end
			7'd4: begin plain = 7'h33; shifted = 7'h23; end
			7'd5: begin plain = 7'h34; shifted = 7'h24; end
			7'd6: begin plain = 7'h35; shifted = 7'h25; end
			7'd7: begin plain = 7'h36; shifted = 7'h5E; end
			7'd8: begin plain = 7'h37; shifted = 7'h26; end
			7'd9: begin plain = 7'h38; shifted = 7'h2A; end
			7'd10: begin plain = 7'h39; shifted = 7'h28; end
			7'd11: begin plain = 7'h30; shifted = 7'h29; end
			7'd12: begin plain = 7'h2D; shifted = 7'h5F; end
			7'd13: begin plain = 7'h3D; shifted = 7'h2B; end
			7'd14: begin plain = 7'h08; shifted = 7'h08; end
			7'd15: begin plain = 7'h09; shifted = 7'h09; end
			7'd16: begin plain = 7'h71; shifted = 7'h51; end
			7'd17: begin plain = 7'h77; shifted = 7'h57; end
			7'd18: begin plain = 7'h65; shifted = 7'h45; end
			7'd19: begin plain = 7'h72; shifted = 7'h52; end
			7'd20: begin plain = 7'h74; shifted = 7'h54; end
			7'd21: begin plain = 7'h79; shifted = 7'h59; end
			7'd22: begin plain = 7'h75; shifted = 7'h55; end
			7'd23: begin plain = 7'h69; shifted = 7'h49; end
			7'd24: begin plain = 7'h6F; shifted = 7'h4F; end
			7'd25: begin plain = 7'h70; shifted = 7'h50; end
			7'd26: begin plain = 7'h5B; shifted = 7'h7B; end
			7'd27: begin plain = 7'h5D; shifted = 7'h7D; end
			7'd28: begin plain = 7'h0A; shifted = 7'h0A; end
			7'd30: begin plain = 7'h61; shifted = 7'h41; end
			7'd31: begin plain = 7'h73; shifted = 7'h53; end
			7'd32: begin plain = 7'h64; shifted = 7'h44; end
			7'd33: begin plain = 7'h66; shifted = 7'h46; end
			7'd34: begin plain = 7'h67; shifted = 7'h47; end
			7'd35: begin plain = 7'h68; shifted = 7'h48; end
			7'd36: begin plain = 7'h6A; shifted = 7'h4A; end
			7'd37: begin plain = 7'h6B; shifted = 7'h4B; end
			7'd38: begin plain = 7'h6C; shifted = 7'h4C; end
			7'd39: begin plain = 7'h3B; shifted = 7'h3A; end
			7'd40: begin plain = 7'h27; shifted = 7'h22; end
			7'd41: begin plain = 7'h60; shifted = 7'h7E; end
			7'd43: begin plain = 7'h5C; shifted = 7'h7C; end
			7'd44: begin plain = 7'h7A; shifted = 7'h5A; end
			7'd45: begin plain = 7'h78; shifted = 7'h58; end
			7'd46: begin plain = 7'h63; shifted = 7'h43; end
			7'd47: begin plain = 7'h76; shifted = 7'h56; end
			7'd48: begin plain = 7'h62; shifted = 7'h42; end
			7'd49: begin plain = 7'h6E; shifted = 7'h4E; end
			7'd50: begin plain = 7'h6D; shifted = 7'h4D; end
			7'd51: begin plain = 7'h2C; shifted = 7'h3C; end
			7'd52: begin plain = 7'h2E; shifted = 7'h3E; end
			7'd53: begin plain = 7'h2F; shifted = 7'h3F; end
			7'd55: begin plain = 7'h2A; shifted = 7'h2A; end
			7'd57: begin plain = 7'h20; shifted = 7'h20; end
			7'd74: begin plain = 7'h2D; shifted = 7'h2D; end
			7'd78: begin plain = 7'h2B; shifted = 7'h2B; end
			default: begin plain = '0; shifted = '0; end
		endcase
		return shift ? shifted : plain;
	endfunction

endpackage

/* src/sc2a_ram.sv */
// ----------------------------------------------------------------------------
// sc2a_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sc2a_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/scancode_to_ascii_fifo.sv */
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo
// set-1 scan codes to us ascii with a ring buffer of DEPTH-1 characters
// ----------------------------------------------------------------------------
// read path: a read result passes the stage register, then the master side output register
// throughput: 1 item per cycle, but the slave side stalls while one read
// result waits in the stage register and another sits on the master side, so
// back-to-back reads stall even when the master side is ready
// reset: pointers, shift flag and valid flags clear at once; the character
// ram is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scancode_to_ascii_fifo
	import sc2a_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [CODE_W-1:0] s_axis_tdata,  // [7:0] scan_code
	input  logic              s_axis_tuser,  // [0] opcode
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,  // [6:0] read_char, [7] zero
	output logic              m_axis_tuser   // [0] read_empty
);

	ptr_t  wr_ptr_q;
	ptr_t  rd_ptr_q;
	logic  shift_q;
	logic  valid_s1;
	logic  empty_s1;
	char_t rdata;

	logic  in_xfer;
	logic  is_read;
	logic  released;
	logic  is_shift;
	char_t ascii;
	ptr_t  wr_next;
	logic  fifo_full;
	logic  fifo_empty;
	logic  push;
	logic  pop;
	logic  advance;

	assign s_axis_tready = !(valid_s1 && m_axis_tvalid);
	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign is_read = (s_axis_tuser == OP_READ);
	assign released = s_axis_tdata[CODE_W-1];
	assign is_shift = (s_axis_tdata[CODE_W-2:0] == KEY_LSHIFT)
		|| (s_axis_tdata[CODE_W-2:0] == KEY_RSHIFT);
	assign ascii = scan_to_ascii(s_axis_tdata[CODE_W-2:0], shift_q);
	assign wr_next = ptr_next(wr_ptr_q);
	assign fifo_full = (wr_next == rd_ptr_q);
	assign fifo_empty = (wr_ptr_q == rd_ptr_q);
	assign push = in_xfer && !is_read && !released && !is_shift
		&& (ascii != '0) && !fifo_full;
	assign pop = in_xfer && is_read && !fifo_empty;
	assign advance = valid_s1 && (!m_axis_tvalid || m_axis_tready);

	sc2a_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (push),
		.waddr(wr_ptr_q),
		.wdata(ascii),
		.re   (pop),
		.raddr(rd_ptr_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			shift_q <= 1'b0;
			valid_s1 <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_next;
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (in_xfer && !is_read && is_shift) begin
				shift_q <= !released;
			end
			if (in_xfer && is_read) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_xfer && is_read) begin
			empty_s1 <= fifo_empty;
		end
		if (advance) begin
			m_axis_tdata <= {1'b0, (empty_s1 ? char_t'(0) : rdata)};
			m_axis_tuser <= empty_s1;
		end
	end

	`ASSERT_CLK(a_empty_has_no_char, clk, arst_n,
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0)
	`ASSERT_CLK(a_empty_read_flagged, clk, arst_n,
		in_xfer && is_read && fifo_empty |=> valid_s1 && empty_s1)
	`ASSERT_CLK(a_rd_ptr_moves_on_pop, clk, arst_n,
		!$stable(rd_ptr_q) |-> $past(pop))
	`ASSERT_CLK(a_ptr_in_range, clk, arst_n,
		32'(wr_ptr_q) < DEPTH && 32'(rd_ptr_q) < DEPTH)

endmodule
